[design/ctmv_pkg.sv]
// package for the colour tolerance match and vote core
// holds sizes, register codes, reset values and the transfer structs
// no dependencies
package ctmv_pkg;

  // table and channel sizes
  localparam int MAX_COLORS   = 8;
  localparam int CHANNEL_BITS = 16;
  localparam int IDX_W        = $clog2(MAX_COLORS);
  localparam int CNT_W        = $clog2(MAX_COLORS + 1);
  localparam int SUM_W        = 8 + IDX_W;

  // label reported when nothing is certain
  localparam logic [7:0] UNKNOWN_LABEL = 8'd117;

  // input commands
  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CERTAINTY   = 2'd3;

  // configuration reset values
  localparam logic [7:0] RST_TOLERANCE   = 8'd10;
  localparam logic [3:0] RST_COLOR_COUNT = 4'd1;
  localparam logic [7:0] RST_SAMPLE_SIZE = 8'd1;
  localparam logic [7:0] RST_CERTAINTY   = 8'd128;

  // input transfer
  typedef struct packed {
    logic        command;
    logic [2:0]  entry_index;
    logic [15:0] red_value;
    logic [15:0] green_value;
    logic [15:0] blue_value;
    logic [7:0]  entry_label;
  } in_item_t;

  // result transfer
  typedef struct packed {
    logic [7:0] sample_label;
    logic       sample_matched;
    logic       vote_valid;
    logic [7:0] vote_label;
  } out_item_t;

  // one reference table entry
  typedef struct packed {
    logic [7:0]              label;
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] red;
  } ref_entry_t;

endpackage

[design/color_tolerance_match_vote_core.sv]
// colour tolerance match and vote core, top level
// reference table, vote counters and a small sequencer with one shared compare unit
// depends on ctmv_pkg
//
// Usage: an item is taken on a rising edge with start high and busy low.
// A write item (command 0) loads one reference entry in that same cycle and its
// result (no match, labels 'u') appears on the next cycle; busy stays low.
// A classify item (command 1) walks the table one entry at a time (table
// read, then the tolerance compare) until the first match, then checks whether
// the vote window is complete. A completed window with entries in use adds a
// scan over their vote counters, a multiply step and a decision step; busy is
// high throughout.
// Each result is shown for exactly one cycle with out_valid high; the receiver
// cannot stall, and the next item may be taken in that same cycle.
// Configuration goes over cfg_valid/cfg_ready/cfg_index/cfg_wdata, ready while
// idle. Synchronous reset clears control, vote counters, sample count and loads
// the register reset values; the reference table is undefined until written.
module color_tolerance_match_vote_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  ctmv_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  output ctmv_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ctmv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_wdata
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_WIN  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_DEC  = 3'd6;

  localparam int CB  = ctmv_pkg::CHANNEL_BITS;
  localparam int IW  = ctmv_pkg::IDX_W;
  localparam int NW  = ctmv_pkg::CNT_W;
  localparam int SW  = ctmv_pkg::SUM_W;

  logic [2:0] state_r, state_nxt;

  // configuration registers
  logic [7:0] tolerance_r, sample_size_r, certainty_r;
  logic [3:0] color_count_r;

  // per item working registers
  logic [CB-1:0]  red_r, green_r, blue_r, red_nxt, green_nxt, blue_nxt;
  logic [IW-1:0]  cnt_r, cnt_nxt;
  logic [IW-1:0]  best_r, best_nxt;
  logic [7:0]     best_votes_r, best_votes_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic [7:0]     label_r, label_nxt;
  logic           matched_r, matched_nxt;
  logic [16:0]    prod_r, prod_nxt;
  logic [8:0]     unknown_r, unknown_nxt;
  logic [7:0]     samples_seen_r, samples_seen_nxt;

  logic           out_valid_r, out_valid_nxt;
  ctmv_pkg::out_item_t out_item_r, out_item_nxt;

  // reference table and vote counters
  ctmv_pkg::ref_entry_t ref_mem [ctmv_pkg::MAX_COLORS];
  ctmv_pkg::ref_entry_t mem_q;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr, mem_raddr;
  ctmv_pkg::ref_entry_t mem_wdata;

  logic [7:0] votes_r [ctmv_pkg::MAX_COLORS];
  logic       vote_inc, vote_clr;

  // derived values
  logic          accept;
  logic [NW-1:0] n_active;
  logic          last_entry;
  logic [8:0]    window;
  logic [8:0]    win_size;
  logic          window_done;
  logic [7:0]    cur_votes;
  logic          near_r, near_g, near_b, entry_hit;
  logic [SW-1:0] sum_ext;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // entries in use, saturated to the table depth
  assign n_active = (int'(color_count_r) > ctmv_pkg::MAX_COLORS)
                    ? NW'(ctmv_pkg::MAX_COLORS) : NW'(color_count_r);
  assign last_entry = (NW'(cnt_r) == NW'(n_active - NW'(1)));

  // window length including the current sample
  assign window      = {1'b0, samples_seen_r} + 9'd1;
  assign win_size    = (sample_size_r == 8'd0) ? 9'd1 : {1'b0, sample_size_r};
  assign window_done = (window >= win_size);

  assign cur_votes = votes_r[cnt_r];
  assign sum_ext   = SW'(cur_votes);

  // shared tolerance compare, all three channels of one entry
  function automatic logic chan_near(input logic [CB-1:0] s, input logic [CB-1:0] r,
                                     input logic [7:0] tol);
    logic [CB:0] diff;
    begin
      diff = (s >= r) ? ({1'b0, s} - {1'b0, r}) : ({1'b0, r} - {1'b0, s});
      chan_near = (diff <= (CB+1)'(tol));
    end
  endfunction

  assign near_r    = chan_near(red_r, mem_q.red, tolerance_r);
  assign near_g    = chan_near(green_r, mem_q.green, tolerance_r);
  assign near_b    = chan_near(blue_r, mem_q.blue, tolerance_r);
  assign entry_hit = near_r && near_g && near_b;

  // reference table write and registered read
  assign mem_we    = accept && (in_item.command == ctmv_pkg::CMD_WRITE) &&
                     (int'(in_item.entry_index) < ctmv_pkg::MAX_COLORS);
  assign mem_waddr = IW'(in_item.entry_index);
  assign mem_wdata = '{label: in_item.entry_label,
                       blue:  in_item.blue_value[CB-1:0],
                       green: in_item.green_value[CB-1:0],
                       red:   in_item.red_value[CB-1:0]};
  assign mem_raddr = (state_r == S_MUL) ? best_r : cnt_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ref_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= ref_mem[mem_raddr];
  end

  // vote counters, saturating increment and clear at window end
  assign vote_inc = (state_r == S_CMP) && entry_hit;
  assign vote_clr = (state_r == S_DEC) || ((state_r == S_WIN) && window_done &&
                                           (n_active == '0));

  always_ff @(posedge clk) begin
    if (!rst_n || vote_clr) begin
      for (int i = 0; i < ctmv_pkg::MAX_COLORS; i++) begin
        votes_r[i] <= 8'd0;
      end
    end else if (vote_inc && (cur_votes != 8'd255)) begin
      votes_r[cnt_r] <= cur_votes + 8'd1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r   <= ctmv_pkg::RST_TOLERANCE;
      color_count_r <= ctmv_pkg::RST_COLOR_COUNT;
      sample_size_r <= ctmv_pkg::RST_SAMPLE_SIZE;
      certainty_r   <= ctmv_pkg::RST_CERTAINTY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ctmv_pkg::CFG_TOLERANCE:   tolerance_r   <= cfg_wdata;
        ctmv_pkg::CFG_COLOR_COUNT: color_count_r <= cfg_wdata[3:0];
        ctmv_pkg::CFG_SAMPLE_SIZE: sample_size_r <= cfg_wdata;
        ctmv_pkg::CFG_CERTAINTY:   certainty_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt        = state_r;
    red_nxt          = red_r;
    green_nxt        = green_r;
    blue_nxt         = blue_r;
    cnt_nxt          = cnt_r;
    best_nxt         = best_r;
    best_votes_nxt   = best_votes_r;
    sum_nxt          = sum_r;
    label_nxt        = label_r;
    matched_nxt      = matched_r;
    prod_nxt         = prod_r;
    unknown_nxt      = unknown_r;
    samples_seen_nxt = samples_seen_r;
    out_valid_nxt    = 1'b0;
    out_item_nxt     = out_item_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.command == ctmv_pkg::CMD_WRITE) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{sample_label: ctmv_pkg::UNKNOWN_LABEL, sample_matched: 1'b0,
                              vote_valid: 1'b0, vote_label: ctmv_pkg::UNKNOWN_LABEL};
          end else begin
            red_nxt     = in_item.red_value[CB-1:0];
            green_nxt   = in_item.green_value[CB-1:0];
            blue_nxt    = in_item.blue_value[CB-1:0];
            cnt_nxt     = '0;
            label_nxt   = ctmv_pkg::UNKNOWN_LABEL;
            matched_nxt = 1'b0;
            state_nxt   = (n_active == '0) ? S_WIN : S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (entry_hit) begin
          label_nxt   = mem_q.label;
          matched_nxt = 1'b1;
          state_nxt   = S_WIN;
        end else if (last_entry) begin
          state_nxt = S_WIN;
        end else begin
          cnt_nxt   = cnt_r + IW'(1);
          state_nxt = S_RD;
        end
      end
      S_WIN: begin
        if (!window_done) begin
          samples_seen_nxt = window[7:0];
          out_valid_nxt    = 1'b1;
          out_item_nxt     = '{sample_label: label_r, sample_matched: matched_r,
                               vote_valid: 1'b0, vote_label: ctmv_pkg::UNKNOWN_LABEL};
          state_nxt        = S_IDLE;
        end else if (n_active == '0) begin
          samples_seen_nxt = 8'd0;
          out_valid_nxt    = 1'b1;
          out_item_nxt     = '{sample_label: label_r, sample_matched: matched_r,
                               vote_valid: 1'b1, vote_label: ctmv_pkg::UNKNOWN_LABEL};
          state_nxt        = S_IDLE;
        end else begin
          cnt_nxt        = '0;
          best_nxt       = '0;
          best_votes_nxt = 8'd0;
          sum_nxt        = '0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // one counter per cycle, lowest index wins a tie
        if (best_votes_r < cur_votes) begin
          best_nxt       = cnt_r;
          best_votes_nxt = cur_votes;
        end
        sum_nxt = sum_r + sum_ext;
        if (last_entry) begin
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      S_MUL: begin
        prod_nxt    = 17'(certainty_r) * 17'(window);
        unknown_nxt = (sum_r > SW'(window)) ? 9'd0 : 9'(SW'(window) - sum_r);
        state_nxt   = S_DEC;
      end
      S_DEC: begin
        samples_seen_nxt = 8'd0;
        out_valid_nxt    = 1'b1;
        out_item_nxt     = '{sample_label: label_r, sample_matched: matched_r,
                             vote_valid: 1'b1, vote_label: ctmv_pkg::UNKNOWN_LABEL};
        if (({1'b0, best_votes_r} > unknown_r) &&
            ({1'b0, best_votes_r, 8'd0} > prod_r)) begin
          out_item_nxt.vote_label = mem_q.label;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      samples_seen_r <= 8'd0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      samples_seen_r <= samples_seen_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    red_r        <= red_nxt;
    green_r      <= green_nxt;
    blue_r       <= blue_nxt;
    cnt_r        <= cnt_nxt;
    best_r       <= best_nxt;
    best_votes_r <= best_votes_nxt;
    sum_r        <= sum_nxt;
    label_r      <= label_nxt;
    matched_r    <= matched_nxt;
    prod_r       <= prod_nxt;
    unknown_r    <= unknown_nxt;
    out_item_r   <= out_item_nxt;
  end

  // a classify transfer always makes the core busy
  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.command == ctmv_pkg::CMD_CLASSIFY) |=> busy)
    else $error("classify transfer did not start the sequencer");

  // a closed window leaves the sample count at zero
  a_window_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.vote_valid |-> samples_seen_r == 8'd0)
    else $error("sample count not cleared after vote");

  // unmatched result carries the unknown label
  a_nomatch_label: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.sample_matched |-> out_item.sample_label == ctmv_pkg::UNKNOWN_LABEL)
    else $error("unmatched sample with a real label");

  // no vote label outside a window close
  a_vote_label: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.vote_valid |-> out_item.vote_label == ctmv_pkg::UNKNOWN_LABEL)
    else $error("vote label outside a window close");

endmodule

[sim/color_tolerance_match_vote_core_tb.sv]
// testbench for color_tolerance_match_vote_core: directed and random table writes and samples
// a matcher class predicts every result and checks the result transfers in order
// depends on ctmv_pkg and the core rtl
module color_tolerance_match_vote_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctmv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 32;

  // predicts the match and vote result of each accepted item and checks the results
  class colour_matcher;
    logic [7:0]  tolerance;
    logic [3:0]  color_count;
    logic [7:0]  sample_size;
    logic [7:0]  certainty;
    logic [15:0] ref_red   [MAX_COLORS];
    logic [15:0] ref_green [MAX_COLORS];
    logic [15:0] ref_blue  [MAX_COLORS];
    logic [7:0]  ref_label [MAX_COLORS];
    logic [7:0]  votes     [MAX_COLORS];
    logic [7:0]  samples_seen;
    out_item_t   due_results[$];
    int mismatches, writes_seen, samples_total, matches_total;
    int windows_total, windows_decided;

    function new();
      tolerance    = RST_TOLERANCE;
      color_count  = RST_COLOR_COUNT;
      sample_size  = RST_SAMPLE_SIZE;
      certainty    = RST_CERTAINTY;
      samples_seen = '0;
      for (int i = 0; i < MAX_COLORS; i++) begin
        ref_red[i]   = '0;
        ref_green[i] = '0;
        ref_blue[i]  = '0;
        ref_label[i] = '0;
        votes[i]     = '0;
      end
      mismatches = 0;
      writes_seen = 0;
      samples_total = 0;
      matches_total = 0;
      windows_total = 0;
      windows_decided = 0;
    endfunction

    function int active_entries();
      return (color_count > MAX_COLORS) ? MAX_COLORS : int'(color_count);
    endfunction

    function bit channel_close(logic [15:0] smp, logic [15:0] refc);
      int diff;
      diff = int'(smp) - int'(refc);
      return (diff <= int'(tolerance)) && (-diff <= int'(tolerance));
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_TOLERANCE:   tolerance   = val;
        CFG_COLOR_COUNT: color_count = val[3:0];
        CFG_SAMPLE_SIZE: sample_size = val;
        CFG_CERTAINTY:   certainty   = val;
        default: ;
      endcase
    endfunction

    // accepted input transfer: update the table or vote, queue the expected result
    function void take_item(in_item_t it);
      out_item_t res;
      int n, best, win, wsize, sum, unknown, top;
      res.sample_label   = UNKNOWN_LABEL;
      res.sample_matched = 1'b0;
      res.vote_valid     = 1'b0;
      res.vote_label     = UNKNOWN_LABEL;
      if (it.command == CMD_WRITE) begin
        ref_red[it.entry_index]   = it.red_value;
        ref_green[it.entry_index] = it.green_value;
        ref_blue[it.entry_index]  = it.blue_value;
        ref_label[it.entry_index] = it.entry_label;
        writes_seen++;
      end else begin
        samples_total++;
        n = active_entries();
        // first entry within tolerance on all three channels
        for (int i = 0; i < n; i++) begin
          if (channel_close(it.red_value, ref_red[i]) &&
              channel_close(it.green_value, ref_green[i]) &&
              channel_close(it.blue_value, ref_blue[i])) begin
            res.sample_label   = ref_label[i];
            res.sample_matched = 1'b1;
            if (votes[i] != 8'hFF) votes[i]++;
            matches_total++;
            break;
          end
        end
        // window close: pick the leader, apply unknown and certainty tests
        win   = int'(samples_seen) + 1;
        wsize = (sample_size == 0) ? 1 : int'(sample_size);
        if (win >= wsize) begin
          res.vote_valid = 1'b1;
          best = 0;
          sum  = 0;
          for (int i = 0; i < n; i++) begin
            if (votes[best] < votes[i]) best = i;
            sum += votes[i];
          end
          unknown = (sum > win) ? 0 : win - sum;
          top = int'(votes[best]);
          if (n > 0 && top > unknown && top * 256 > int'(certainty) * win) begin
            res.vote_label = ref_label[best];
            windows_decided++;
          end
          windows_total++;
          for (int i = 0; i < MAX_COLORS; i++) votes[i] = '0;
          samples_seen = '0;
        end else begin
          samples_seen = 8'(win);
        end
      end
      due_results.push_back(res);
    endfunction

    // accepted result transfer against the oldest expectation
    function void compare_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result label %0d matched %0d vote %0d/%0d", $realtime,
                   got.sample_label, got.sample_matched, got.vote_valid, got.vote_label);
        return;
      end
      want = due_results.pop_front();
      if (got.sample_label !== want.sample_label || got.sample_matched !== want.sample_matched
          || got.vote_valid !== want.vote_valid || got.vote_label !== want.vote_label) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch, expected label %0d matched %0d vote %0d/%0d, got %0d %0d %0d/%0d",
                   $realtime, want.sample_label, want.sample_matched, want.vote_valid,
                   want.vote_label, got.sample_label, got.sample_matched, got.vote_valid,
                   got.vote_label);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TOLERANCE;
  logic [7:0] cfg_wdata = '0;
  int cycle_count = 0;

  colour_matcher matcher = new();

  color_tolerance_match_vote_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // transfer monitor: results first, since an item may be taken in a result cycle
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) matcher.compare_result(out_item);
      if (start && !busy) matcher.take_item(in_item);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic cmd, logic [2:0] idx, logic [15:0] r,
                                         logic [15:0] g, logic [15:0] b, logic [7:0] lab);
    in_item_t it;
    it.command     = cmd;
    it.entry_index = idx;
    it.red_value   = r;
    it.green_value = g;
    it.blue_value  = b;
    it.entry_label = lab;
    return it;
  endfunction

  // value within +/- spread of base, clamped to the channel range
  function automatic logic [15:0] jitter(logic [15:0] base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // distinct labels: low bits carry the entry index
  function automatic logic [7:0] entry_tag(logic [2:0] idx);
    return {5'($urandom_range(0, 31)), idx};
  endfunction

  function automatic in_item_t sample_near(int e, int spread);
    return make_item(CMD_CLASSIFY, 3'($urandom), jitter(matcher.ref_red[e], spread),
                     jitter(matcher.ref_green[e], spread), jitter(matcher.ref_blue[e], spread),
                     8'($urandom));
  endfunction

  // start stays high when the next item follows straight on
  task automatic send_item(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // sender pause until every expected result has come
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (matcher.due_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    matcher.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic [3:0] sel, input logic [7:0] tol,
                              input logic [7:0] cnt, input logic [7:0] wsize,
                              input logic [7:0] cert);
    if (sel[0]) put_reg(CFG_TOLERANCE, tol);
    if (sel[1]) put_reg(CFG_COLOR_COUNT, cnt);
    if (sel[2]) put_reg(CFG_SAMPLE_SIZE, wsize);
    if (sel[3]) put_reg(CFG_CERTAINTY, cert);
    cfg_valid <= 1'b0;
  endtask

  // random mix: well-formed samples near table entries, some writes, some noise
  task automatic run_random(input int count, input bit idle_en);
    in_item_t it;
    int pick, e, n, tol;
    logic [2:0] idx;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      n    = matcher.active_entries();
      tol  = int'(matcher.tolerance);
      if (pick < 12) begin
        idx = 3'($urandom);
        e   = $urandom_range(0, MAX_COLORS - 1);
        if ($urandom_range(0, 1) == 0)
          it = make_item(CMD_WRITE, idx, jitter(matcher.ref_red[e], 3 * tol + 8),
                         jitter(matcher.ref_green[e], 3 * tol + 8),
                         jitter(matcher.ref_blue[e], 3 * tol + 8), entry_tag(idx));
        else
          it = make_item(CMD_WRITE, idx, 16'($urandom), 16'($urandom), 16'($urandom),
                         entry_tag(idx));
      end else if (pick < 85) begin
        e  = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, MAX_COLORS - 1);
        it = sample_near(e, ($urandom_range(0, 2) == 0) ? tol + 2 : tol);
      end else begin
        it = make_item(CMD_CLASSIFY, 3'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 8'($urandom));
      end
      send_item(it);
      if (k != count - 1 && idle_en && $urandom_range(0, 99) < 10) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 32)) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [7:0] tol, cnt, wsize, cert;
    logic [3:0] sel;
    logic [15:0] full;
    full = 16'hFFFF;

    // synchronous reset
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table, extremes at both ends
    send_item(make_item(CMD_WRITE, 3'd0, 16'd0, 16'd0, 16'd0, entry_tag(3'd0)));
    for (int i = 1; i < MAX_COLORS - 1; i++)
      send_item(make_item(CMD_WRITE, 3'(i), 16'($urandom), 16'($urandom), 16'($urandom),
                          entry_tag(3'(i))));
    send_item(make_item(CMD_WRITE, 3'd7, full, full, full, entry_tag(3'd7)));

    // reset settings: exact hit, tolerance boundary, one beyond it
    send_item(make_item(CMD_CLASSIFY, 3'd0, 16'd0, 16'd0, 16'd0, 8'd0));
    send_item(make_item(CMD_CLASSIFY, 3'd0, 16'd10, 16'd10, 16'd10, 8'd0));
    send_item(make_item(CMD_CLASSIFY, 3'd0, 16'd11, 16'd0, 16'd0, 8'd0));
    send_item(make_item(CMD_CLASSIFY, 3'd0, 16'd0, 16'd0, 16'd10, 8'd0));

    // zero tolerance, entry count beyond the table, three-sample window
    drain();
    program_regs(4'b1111, 8'd0, 8'd15, 8'd3, 8'd0);
    send_item(sample_near(7, 0));
    send_item(sample_near(3, 0));
    send_item(sample_near(7, 0));

    // no entries in use
    drain();
    program_regs(4'b0110, 8'd0, 8'd0, 8'd2, 8'd0);
    send_item(sample_near(0, 0));
    send_item(sample_near(0, 0));

    // window shortened mid-way via size zero, full certainty
    drain();
    program_regs(4'b0110, 8'd0, 8'd8, 8'd5, 8'd0);
    send_item(sample_near(2, 0));
    send_item(make_item(CMD_CLASSIFY, 3'd5, 16'h1234, 16'h8765, 16'h4321, 8'd200));
    drain();
    program_regs(4'b1100, 8'd0, 8'd0, 8'd0, 8'd255);
    send_item(sample_near(2, 0));

    // widest tolerance, entry count cut down mid-window
    drain();
    program_regs(4'b1101, 8'd255, 8'd0, 8'd4, 8'd128);
    send_item(sample_near(5, 255));
    send_item(sample_near(5, 255));
    drain();
    program_regs(4'b0010, 8'd0, 8'd2, 8'd0, 8'd0);
    send_item(sample_near(1, 255));
    send_item(sample_near(0, 255));

    // random phases, settings change while windows may be open
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      case ($urandom_range(0, 9))
        0:       tol = 8'd0;
        1:       tol = 8'd255;
        default: tol = 8'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 9))
        0:       cnt = 8'd0;
        1:       cnt = 8'($urandom_range(9, 15));
        default: cnt = 8'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
        0:       wsize = 8'd0;
        default: wsize = 8'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
        0:       cert = 8'd0;
        1:       cert = 8'd255;
        default: cert = 8'($urandom);
      endcase
      sel = (ph == 0) ? 4'b1111 : 4'($urandom_range(1, 15));
      if (ph == 8) begin
        wsize = 8'd255;
        sel[2] = 1'b1;
      end
      program_regs(sel, tol, cnt, wsize, cert);
      run_random(42, !(ph >= 4 && ph <= 6));
    end

    // wind down
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d table writes and %0d samples, %0d of them matched",
             matcher.writes_seen, matcher.samples_total, matcher.matches_total);
    $display("%0d vote windows closed, %0d gave a label; %0d mismatches",
             matcher.windows_total, matcher.windows_decided, matcher.mismatches);
    if (matcher.mismatches == 0 && matcher.due_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
